// ----- design/rtcep_pkg.sv -----
// ----------------------------------------------------------------------------
// rtcep_pkg
// Shared types, register indexes and calendar helpers for the rtc snapshot
// to epoch seconds pipeline.
// ----------------------------------------------------------------------------
package rtcep_pkg;

  // register indexes on the config port (byte address = 4 * index)
  localparam logic [1:0] REG_CENTURY_PRESENT = 2'd0;
  localparam logic [1:0] REG_BINARY_MODE     = 2'd1;
  localparam logic [1:0] REG_HOUR24_MODE     = 2'd2;
  localparam logic [1:0] REG_BASE_YEAR       = 2'd3;

  localparam logic [13:0] BASE_YEAR_RESET = 14'd2020;
  localparam logic [7:0]  BASE_HUND_RESET = 8'd20;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 2^15
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic [14:0] FIRST_COUNTED_YEAR = 15'd1971;
  localparam logic [14:0] YEAR_BEFORE_EPOCH  = 15'd1969;
  // leap days in years 1 .. 1969
  localparam logic [23:0] LEAPS_TO_1969      = 24'd477;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN       = 6'd60;

  typedef struct packed {
    logic        century_present;
    logic        binary_mode;
    logic        hour24_mode;
    logic [13:0] base_year;
    logic [7:0]  base_hund;   // base_year / 100, kept alongside the register
  } cfg_t;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] yr;
    logic [7:0] cen;
  } raw_t;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] mon;
  } fields_t;

  typedef struct packed {
    fields_t     f;
    logic [14:0] year;
  } year_item_t;

  typedef struct packed {
    fields_t     f;
    logic [14:0] year;
    logic [31:0] total_days;
    logic [19:0] tod;
  } day_item_t;

  // plain bcd decode, bad nibbles are converted arithmetically
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
  endfunction

  // hour bcd decode: tens digit from bits 6..4, pm flag passes through
  function automatic logic [7:0] bcd_hour(input logic [7:0] b);
    logic [6:0] v;
    v = 7'(b[3:0]) + 7'(b[6:4]) * 7'd10;
    return {b[7], v};
  endfunction

  // remainder by 24 for values below 192
  function automatic logic [7:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd96) r = r - 8'd96;
    if (r >= 8'd48) r = r - 8'd48;
    if (r >= 8'd24) r = r - 8'd24;
    return r;
  endfunction

  // days in the completed months before month m, zero outside 2..12
  function automatic logic [8:0] days_before(input logic [7:0] m);
    logic [8:0] d;
    case (m)
      8'd2:    d = 9'd31;
      8'd3:    d = 9'd59;
      8'd4:    d = 9'd90;
      8'd5:    d = 9'd120;
      8'd6:    d = 9'd151;
      8'd7:    d = 9'd181;
      8'd8:    d = 9'd212;
      8'd9:    d = 9'd243;
      8'd10:   d = 9'd273;
      8'd11:   d = 9'd304;
      8'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- design/cmos_rtc_to_epoch_seconds_unit.sv -----
// ----------------------------------------------------------------------------
// cmos_rtc_to_epoch_seconds_unit
// Decodes one snapshot of raw rtc bytes into calendar fields and seconds
// since 1970-01-01 00:00, modulo 2^32.
// ----------------------------------------------------------------------------
// usage
//   request channel snap_valid / snap_stall carries the seven raw bytes;
//   result channel res_valid / res_stall returns the decoded fields,
//   full_year and epoch_seconds; the apb-style config port holds
//   century_present, binary_mode, hour24_mode, base_year at 0, 4, 8, 12
// pipeline and throughput
//   six register stages: bcd decode, year, year quotients, day count,
//   day multiply, final add; one request is taken every cycle unless
//   res_stall holds back a full pipe
// reset and stalls
//   rst clears all stage valid bits and loads base_year 2020 with base_hund 20, mode bits 0;
//   a held result keeps its value while res_stall is high, bubbles in front
//   of it still fill, and snap_stall rises only once every stage is full
// ----------------------------------------------------------------------------
module cmos_rtc_to_epoch_seconds_unit (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        snap_valid,
  output logic        snap_stall,
  input  logic [7:0]  raw_second,
  input  logic [7:0]  raw_minute,
  input  logic [7:0]  raw_hour,
  input  logic [7:0]  raw_day,
  input  logic [7:0]  raw_month,
  input  logic [7:0]  raw_year,
  input  logic [7:0]  raw_century,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  second_out,
  output logic [7:0]  minute_out,
  output logic [7:0]  hour_out,
  output logic [7:0]  day_out,
  output logic [7:0]  month_out,
  output logic [14:0] full_year,
  output logic [31:0] epoch_seconds
);

  rtcep_pkg::cfg_t        cfg;
  rtcep_pkg::raw_t        raw;
  rtcep_pkg::year_item_t  year_item;
  rtcep_pkg::day_item_t   day_item;
  rtcep_pkg::fields_t     res_fields;
  logic                   year_valid;
  logic                   year_stall;
  logic                   day_valid;
  logic                   day_stall;

  // gather the raw bytes of one request
  assign raw.sec  = raw_second;
  assign raw.min  = raw_minute;
  assign raw.hour = raw_hour;
  assign raw.day  = raw_day;
  assign raw.mon  = raw_month;
  assign raw.yr   = raw_year;
  assign raw.cen  = raw_century;

  rtcep_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stages 1-2: decode bytes, build full year
  rtcep_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (snap_valid),
    .in_stall  (snap_stall),
    .in_data   (raw),
    .out_valid (year_valid),
    .out_stall (year_stall),
    .out_data  (year_item)
  );

  // stages 3-4: days since 1970 and time of day
  rtcep_calendar u_calendar (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (year_valid),
    .in_stall  (year_stall),
    .in_data   (year_item),
    .out_valid (day_valid),
    .out_stall (day_stall),
    .out_data  (day_item)
  );

  // stages 5-6: scale days to seconds, add time of day
  rtcep_epoch u_epoch (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (day_valid),
    .in_stall   (day_stall),
    .in_data    (day_item),
    .out_valid  (res_valid),
    .out_stall  (res_stall),
    .out_fields (res_fields),
    .out_year   (full_year),
    .out_epoch  (epoch_seconds)
  );

  assign second_out = res_fields.sec;
  assign minute_out = res_fields.min;
  assign hour_out   = res_fields.hour;
  assign day_out    = res_fields.day;
  assign month_out  = res_fields.mon;

  // the cached quotient must always match the base_year register
  a_base_hund: assert property (@(posedge clk) disable iff (rst)
    (15'(cfg.base_hund) * 15'd100 <= 15'(cfg.base_year)) &&
    (15'(cfg.base_year) < 15'(cfg.base_hund) * 15'd100 + 15'd100))
    else $error("base_year quotient out of step with register");

  // requests are held back only when the whole pipe is full and blocked
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    snap_stall |-> (res_valid && res_stall && day_valid && year_valid))
    else $error("request stalled while the pipeline has room");

  // the built year never exceeds 25755, the largest that the century and year bytes can give
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (full_year <= 15'd25755))
    else $error("full year out of range");

endmodule

// ----- design/rtcep_regs.sv -----
// ----------------------------------------------------------------------------
// rtcep_regs
// Config register file behind the apb-style port, with base_year / 100
// worked out once at write time.
// ----------------------------------------------------------------------------
module rtcep_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rtcep_pkg::cfg_t     cfg
);

  logic        wr;
  logic [1:0]  idx;
  logic [26:0] hund_prod;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign idx       = paddr[3:2];
  assign hund_prod = 27'(pwdata[13:0]) * 27'(rtcep_pkg::DIV100_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.century_present <= 1'b0;
      cfg.binary_mode     <= 1'b0;
      cfg.hour24_mode     <= 1'b0;
      cfg.base_year       <= rtcep_pkg::BASE_YEAR_RESET;
      cfg.base_hund       <= rtcep_pkg::BASE_HUND_RESET;
    end else if (wr) begin
      case (idx)
        rtcep_pkg::REG_CENTURY_PRESENT: cfg.century_present <= pwdata[0];
        rtcep_pkg::REG_BINARY_MODE:     cfg.binary_mode     <= pwdata[0];
        rtcep_pkg::REG_HOUR24_MODE:     cfg.hour24_mode     <= pwdata[0];
        rtcep_pkg::REG_BASE_YEAR: begin
          cfg.base_year <= pwdata[13:0];
          cfg.base_hund <= hund_prod[26:rtcep_pkg::DIV100_SHIFT];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rtcep_pkg::REG_CENTURY_PRESENT: prdata = {31'd0, cfg.century_present};
      rtcep_pkg::REG_BINARY_MODE:     prdata = {31'd0, cfg.binary_mode};
      rtcep_pkg::REG_HOUR24_MODE:     prdata = {31'd0, cfg.hour24_mode};
      rtcep_pkg::REG_BASE_YEAR:       prdata = {18'd0, cfg.base_year};
      default:                        prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/rtcep_decode.sv -----
// ----------------------------------------------------------------------------
// rtcep_decode
// Stages 1 and 2: bcd or binary decode with the pm fix-up, then the full year.
// ----------------------------------------------------------------------------
module rtcep_decode (
  input  logic                   clk,
  input  logic                   rst,
  input  rtcep_pkg::cfg_t        cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rtcep_pkg::raw_t        in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rtcep_pkg::year_item_t  out_data
);

  logic                 v1;
  logic                 ready1;
  logic                 ready2;
  rtcep_pkg::fields_t   f1;
  logic [7:0]           yr1;
  logic [7:0]           cen1;
  rtcep_pkg::fields_t   f_dec;
  logic [7:0]           yr_dec;
  logic [7:0]           cen_dec;
  logic [7:0]           hour_dec;
  logic [14:0]          year_cen;
  logic [14:0]          year_win;
  logic [14:0]          year_sel;

  assign ready2   = !out_valid || !out_stall;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // stage 1 logic
  always_comb begin
    if (cfg.binary_mode) begin
      f_dec.sec = in_data.sec;
      f_dec.min = in_data.min;
      hour_dec  = in_data.hour;
      f_dec.day = in_data.day;
      f_dec.mon = in_data.mon;
      yr_dec    = in_data.yr;
      cen_dec   = in_data.cen;
    end else begin
      f_dec.sec = rtcep_pkg::bcd_to_bin(in_data.sec);
      f_dec.min = rtcep_pkg::bcd_to_bin(in_data.min);
      hour_dec  = rtcep_pkg::bcd_hour(in_data.hour);
      f_dec.day = rtcep_pkg::bcd_to_bin(in_data.day);
      f_dec.mon = rtcep_pkg::bcd_to_bin(in_data.mon);
      yr_dec    = rtcep_pkg::bcd_to_bin(in_data.yr);
      cen_dec   = rtcep_pkg::bcd_to_bin(in_data.cen);
    end
    if (!cfg.hour24_mode && hour_dec[7]) begin
      f_dec.hour = rtcep_pkg::mod24(8'(hour_dec[6:0]) + 8'd12);
    end else begin
      f_dec.hour = hour_dec;
    end
  end

  // stage 2 logic
  always_comb begin
    year_cen = 15'(yr1) + 15'(cen1) * 15'd100;
    year_win = 15'(yr1) + 15'(cfg.base_hund) * 15'd100;
    if (year_win < 15'(cfg.base_year)) begin
      year_win = year_win + 15'd100;
    end
    year_sel = cfg.century_present ? year_cen : year_win;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) v1        <= in_valid;
      if (ready2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      f1   <= f_dec;
      yr1  <= yr_dec;
      cen1 <= cen_dec;
    end
    if (ready2 && v1) begin
      out_data.f    <= f1;
      out_data.year <= year_sel;
    end
  end

endmodule

// ----- design/rtcep_calendar.sv -----
// ----------------------------------------------------------------------------
// rtcep_calendar
// Stages 3 and 4: year quotients and time of day, then the day count.
// ----------------------------------------------------------------------------
module rtcep_calendar (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rtcep_pkg::year_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rtcep_pkg::day_item_t   out_data
);

  logic                 v3;
  logic                 ready3;
  logic                 ready4;

  // stage 3 registers
  rtcep_pkg::fields_t   f3;
  logic [14:0]          year3;
  logic [14:0]          last3;
  logic [8:0]           qlast3;
  logic [8:0]           qyear3;
  logic [23:0]          y365_3;
  logic                 pre3;
  logic [8:0]           mdays3;
  logic                 mlate3;
  logic [19:0]          tod3;

  logic [14:0]          last_c;
  logic [27:0]          qlast_prod;
  logic [27:0]          qyear_prod;
  logic [14:0]          span_c;
  logic [19:0]          tod_c;

  logic [14:0]          cent_c;
  logic                 leap_c;
  logic [23:0]          ydays_c;
  logic [31:0]          total_c;

  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !v3 || ready4;
  assign in_stall = !ready3;

  // stage 3 logic
  always_comb begin
    last_c     = in_data.year - 15'd1;
    qlast_prod = 28'(last_c) * 28'(rtcep_pkg::DIV100_MUL);
    qyear_prod = 28'(in_data.year) * 28'(rtcep_pkg::DIV100_MUL);
    span_c     = last_c - rtcep_pkg::YEAR_BEFORE_EPOCH;
    tod_c      = 20'(in_data.f.hour) * 20'(rtcep_pkg::SECS_PER_HOUR)
               + 20'(in_data.f.min) * 20'(rtcep_pkg::SECS_PER_MIN)
               + 20'(in_data.f.sec);
  end

  // stage 4 logic
  always_comb begin
    cent_c  = 15'(qyear3) * 15'd100;
    leap_c  = (year3[1:0] == 2'd0) && ((year3 != cent_c) || (qyear3[1:0] == 2'd0));
    // 365 per year plus leap days in 1970 .. last
    ydays_c = y365_3 + 24'(last3[14:2]) - 24'(qlast3) + 24'(qlast3[8:2])
            - rtcep_pkg::LEAPS_TO_1969;
    if (pre3) ydays_c = 24'd0;
    total_c = 32'(ydays_c) + 32'(mdays3) + 32'(mlate3 && leap_c)
            + 32'(f3.day) - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready3) v3        <= in_valid;
      if (ready4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && in_valid) begin
      f3     <= in_data.f;
      year3  <= in_data.year;
      last3  <= last_c;
      qlast3 <= qlast_prod[27:rtcep_pkg::DIV100_SHIFT];
      qyear3 <= qyear_prod[27:rtcep_pkg::DIV100_SHIFT];
      y365_3 <= 24'(span_c) * 24'(rtcep_pkg::DAYS_PER_YEAR);
      pre3   <= in_data.year < rtcep_pkg::FIRST_COUNTED_YEAR;
      mdays3 <= rtcep_pkg::days_before(in_data.f.mon);
      mlate3 <= (in_data.f.mon >= 8'd3) && (in_data.f.mon <= 8'd12);
      tod3   <= tod_c;
    end
    if (ready4 && v3) begin
      out_data.f          <= f3;
      out_data.year       <= year3;
      out_data.total_days <= total_c;
      out_data.tod        <= tod3;
    end
  end

endmodule

// ----- design/rtcep_epoch.sv -----
// ----------------------------------------------------------------------------
// rtcep_epoch
// Stages 5 and 6: days times 86400, then add the time of day.
// ----------------------------------------------------------------------------
module rtcep_epoch (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rtcep_pkg::day_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rtcep_pkg::fields_t     out_fields,
  output logic [14:0]            out_year,
  output logic [31:0]            out_epoch
);

  logic                 v5;
  logic                 ready5;
  logic                 ready6;
  rtcep_pkg::fields_t   f5;
  logic [14:0]          year5;
  logic [31:0]          prod5;
  logic [19:0]          tod5;
  logic [48:0]          prod_c;

  assign ready6   = !out_valid || !out_stall;
  assign ready5   = !v5 || ready6;
  assign in_stall = !ready5;

  // low 32 bits give the wrap modulo 2^32
  assign prod_c = 49'(in_data.total_days) * 49'(rtcep_pkg::SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready5) v5        <= in_valid;
      if (ready6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && in_valid) begin
      f5    <= in_data.f;
      year5 <= in_data.year;
      prod5 <= prod_c[31:0];
      tod5  <= in_data.tod;
    end
    if (ready6 && v5) begin
      out_fields <= f5;
      out_year   <= year5;
      out_epoch  <= prod5 + 32'(tod5);
    end
  end

endmodule
